// ===== hdl/address_range_to_owner_lookup_top_assert.svh =====
// Assertion macros for the range lookup block.
// Clocked on i_clk, disabled while i_rst_n is low; no other dependencies.
`ifndef ADDRESS_RANGE_TO_OWNER_LOOKUP_TOP_ASSERT_SVH
`define ADDRESS_RANGE_TO_OWNER_LOOKUP_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ARLO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ARLO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ARLO_ASSERT_IMP(lbl, ante, cons, msg)
`define ARLO_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/arlo_pkg.sv =====
// Shared constants, codes, types and helpers for the range lookup block.
// No dependencies.
package arlo_pkg;

    localparam int unsigned V4_DEPTH_DEF = 16384;
    localparam int unsigned V6_DEPTH_DEF = 16384;

    localparam int unsigned SLOT_W  = 14;
    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned V4_W    = 32;
    localparam int unsigned ASN_W   = 32;
    localparam int unsigned NAME_W  = 24;
    localparam int unsigned CNT_W   = 15;
    localparam int unsigned NCNT_W  = 25;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_V4_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_V6_ENTRIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_COUNT = 2'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;
    localparam logic FAM_V4     = 1'b0;
    localparam logic FAM_V6     = 1'b1;

    localparam int unsigned V4_WORD_W = 2 * V4_W + ASN_W + NAME_W;
    localparam int unsigned V6_WORD_W = 2 * ADDR_W + ASN_W + NAME_W;

    typedef struct packed {
        logic [ADDR_W-1:0] low;
        logic [ADDR_W-1:0] high;
        logic [ASN_W-1:0]  asn;
        logic [NAME_W-1:0] name;
    } t_entry;

    function automatic int unsigned addr_w(input int unsigned depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== hdl/arlo_in_if.sv =====
// Input channel: valid/ready plus one command beat.
// Depends on arlo_pkg.
interface arlo_in_if;
    import arlo_pkg::*;

    logic                valid;
    logic                ready;
    logic                command;
    logic                family;
    logic [SLOT_W-1:0]   entry_slot;
    logic [ADDR_W-1:0]   range_low;
    logic [ADDR_W-1:0]   range_high;
    logic [ASN_W-1:0]    owner_asn;
    logic [NAME_W-1:0]   owner_name;
    logic [ADDR_W-1:0]   key;

    modport source (output valid, command, family, entry_slot, range_low, range_high,
                    owner_asn, owner_name, key, input ready);
    modport sink (input valid, command, family, entry_slot, range_low, range_high,
                  owner_asn, owner_name, key, output ready);
endinterface

// ===== hdl/arlo_out_if.sv =====
// Output channel: valid/ready plus one lookup result beat.
// Depends on arlo_pkg.
interface arlo_out_if;
    import arlo_pkg::*;

    logic                valid;
    logic                ready;
    logic                found;
    logic [ASN_W-1:0]    asn_out;
    logic [NAME_W-1:0]   name_out;
    logic                name_present;

    modport source (output valid, found, asn_out, name_out, name_present, input ready);
    modport sink (input valid, found, asn_out, name_out, name_present, output ready);
endinterface

// ===== hdl/arlo_ram.sv =====
// Generic single-port RAM, one write or read per cycle, registered read data.
// Depends on arlo_pkg for the address width helper.
module arlo_ram #(
    parameter int unsigned W = 8,
    parameter int unsigned D = 2
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [arlo_pkg::addr_w(D)-1:0]    i_addr,
    input  logic [W-1:0]                      i_wdata,
    output logic [W-1:0]                      o_rdata
);
    import arlo_pkg::*;

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/arlo_ctrl.sv =====
// Lookup sequencer: entry writes, binary search one probe per cycle, bound check.
// Depends on arlo_pkg, arlo_in_if, arlo_out_if.
module arlo_ctrl #(
    parameter int unsigned V4_DEPTH = arlo_pkg::V4_DEPTH_DEF,
    parameter int unsigned V6_DEPTH = arlo_pkg::V6_DEPTH_DEF,
    parameter int unsigned CW = $clog2(((V4_DEPTH > V6_DEPTH) ? V4_DEPTH : V6_DEPTH) + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    arlo_in_if.sink                       i_in,
    arlo_out_if.source                    o_out,
    input  logic [arlo_pkg::CNT_W-1:0]    i_v4_entries,
    input  logic [arlo_pkg::CNT_W-1:0]    i_v6_entries,
    input  logic [arlo_pkg::NCNT_W-1:0]   i_name_count,
    input  arlo_pkg::t_entry              i_v4_rd,
    input  arlo_pkg::t_entry              i_v6_rd,
    output logic                          o_v4_we,
    output logic                          o_v6_we,
    output logic [CW-1:0]                 o_addr
);
    import arlo_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic              r_ovalid, n_ovalid;
    logic [CW-1:0]     r_lo, n_lo;
    logic [CW-1:0]     r_hi, n_hi;
    logic [CW-1:0]     r_addr, n_addr;
    logic              r_fam, n_fam;
    logic              r_cand, n_cand;
    logic [ADDR_W-1:0] r_key, n_key;
    logic              r_found, n_found;
    logic [ASN_W-1:0]  r_asn, n_asn;
    logic [NAME_W-1:0] r_name, n_name;
    logic              r_npres, n_npres;

    logic              w_acc;
    logic              w_out_free;
    logic [CW-1:0]     w_hi4, w_hi6, w_hsel;
    logic              w_slot_ok4, w_slot_ok6;
    t_entry            w_rd;
    logic              w_less;
    logic              w_cover;
    logic [CW:0]       w_sum;

    assign w_acc      = i_in.valid && i_in.ready;
    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_hi4 = ({17'd0, i_v4_entries} > V4_DEPTH) ? CW'(V4_DEPTH) : CW'(i_v4_entries);
    assign w_hi6 = ({17'd0, i_v6_entries} > V6_DEPTH) ? CW'(V6_DEPTH) : CW'(i_v6_entries);
    assign w_hsel = (i_in.family == FAM_V6) ? w_hi6 : w_hi4;
    assign w_slot_ok4 = {18'd0, i_in.entry_slot} < V4_DEPTH;
    assign w_slot_ok6 = {18'd0, i_in.entry_slot} < V6_DEPTH;
    assign w_rd    = (r_fam == FAM_V6) ? i_v6_rd : i_v4_rd;
    assign w_less  = r_key < w_rd.low;
    assign w_cover = r_cand && (r_key <= w_rd.high);

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_addr   = r_addr;
        n_fam    = r_fam;
        n_cand   = r_cand;
        n_key    = r_key;
        n_found  = r_found;
        n_asn    = r_asn;
        n_name   = r_name;
        n_npres  = r_npres;
        o_v4_we  = 1'b0;
        o_v6_we  = 1'b0;
        w_sum    = '0;
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_in.command == CMD_WRITE) begin
                        n_addr  = CW'(i_in.entry_slot);
                        o_v4_we = (i_in.family == FAM_V4) && w_slot_ok4;
                        o_v6_we = (i_in.family == FAM_V6) && w_slot_ok6;
                    end else begin
                        n_fam = i_in.family;
                        n_key = (i_in.family == FAM_V6) ? i_in.key
                                                         : {32'd0, i_in.key[V4_W-1:0]};
                        n_lo  = '0;
                        n_hi  = w_hsel;
                        if (w_hsel == '0) begin
                            n_cand  = 1'b0;
                            n_state = S_CHK;
                        end else begin
                            n_addr  = w_hsel >> 1;
                            n_state = S_SRCH;
                        end
                    end
                end
            end
            S_SRCH: begin
                if (w_less) begin
                    n_hi = r_addr;
                end else begin
                    n_lo = r_addr + 1'b1;
                end
                if (n_lo == n_hi) begin
                    n_cand  = (n_lo != '0);
                    n_addr  = n_lo - 1'b1;
                    n_state = S_CHK;
                end else begin
                    w_sum  = {1'b0, n_lo} + {1'b0, n_hi};
                    n_addr = w_sum[CW:1];
                end
            end
            S_CHK: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_found  = w_cover;
                    n_asn    = w_cover ? w_rd.asn : '0;
                    n_name   = w_cover ? w_rd.name : '0;
                    n_npres  = w_cover && ({1'b0, w_rd.name} < i_name_count);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_addr  <= n_addr;
        r_fam   <= n_fam;
        r_cand  <= n_cand;
        r_key   <= n_key;
        r_found <= n_found;
        r_asn   <= n_asn;
        r_name  <= n_name;
        r_npres <= n_npres;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.found        = r_found;
    assign o_out.asn_out      = r_asn;
    assign o_out.name_out     = r_name;
    assign o_out.name_present = r_npres;
    assign o_addr             = n_addr;
endmodule

// ===== hdl/address_range_to_owner_lookup_top.sv =====
// Range-to-owner lookup, one RAM per family; uses arlo_pkg, arlo_ctrl, arlo_ram.
// Entry write: one accepted beat, no result. Lookup: an accept, then up to ceil(log2(n+1))
// probes (one RAM read each, n = loaded entries, 15 at 16384), then a bound check.
// One lookup in flight: no new beat is taken until the previous lookup has left the
// bound check, and a held result blocks the bound check until it is taken.
// Sync active-low reset clears counts, name count and control; tables undefined until written.
`include "address_range_to_owner_lookup_top_assert.svh"
module address_range_to_owner_lookup_top #(
    parameter int unsigned V4_DEPTH = arlo_pkg::V4_DEPTH_DEF,
    parameter int unsigned V6_DEPTH = arlo_pkg::V6_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    arlo_in_if.sink                          i_in,
    arlo_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [arlo_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [arlo_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import arlo_pkg::*;

    localparam int unsigned CW  = $clog2(((V4_DEPTH > V6_DEPTH) ? V4_DEPTH : V6_DEPTH) + 1);
    localparam int unsigned AW4 = addr_w(V4_DEPTH);
    localparam int unsigned AW6 = addr_w(V6_DEPTH);

    logic [CNT_W-1:0]     r_v4_entries, n_v4_entries;
    logic [CNT_W-1:0]     r_v6_entries, n_v6_entries;
    logic [NCNT_W-1:0]    r_name_count, n_name_count;

    logic                 w_v4_we, w_v6_we;
    logic [CW-1:0]        w_addr;
    logic [V4_WORD_W-1:0] w_v4_wdata, w_v4_rdata;
    logic [V6_WORD_W-1:0] w_v6_wdata, w_v6_rdata;
    t_entry               w_v4_rd, w_v6_rd;
    logic                 w_wr_beat, w_lkp_beat;

    always_comb begin
        n_v4_entries = r_v4_entries;
        n_v6_entries = r_v6_entries;
        n_name_count = r_name_count;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_V4_ENTRIES: n_v4_entries = i_cfg_wdata[CNT_W-1:0];
                CFG_V6_ENTRIES: n_v6_entries = i_cfg_wdata[CNT_W-1:0];
                CFG_NAME_COUNT: n_name_count = i_cfg_wdata[NCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4_entries <= '0;
            r_v6_entries <= '0;
            r_name_count <= '0;
        end else begin
            r_v4_entries <= n_v4_entries;
            r_v6_entries <= n_v6_entries;
            r_name_count <= n_name_count;
        end
    end

    assign w_v4_wdata = {i_in.range_low[V4_W-1:0], i_in.range_high[V4_W-1:0],
                         i_in.owner_asn, i_in.owner_name};
    assign w_v6_wdata = {i_in.range_low, i_in.range_high, i_in.owner_asn, i_in.owner_name};

    assign w_v4_rd.low  = {32'd0, w_v4_rdata[V4_WORD_W-1 -: V4_W]};
    assign w_v4_rd.high = {32'd0, w_v4_rdata[ASN_W+NAME_W+V4_W-1 -: V4_W]};
    assign w_v4_rd.asn  = w_v4_rdata[ASN_W+NAME_W-1 -: ASN_W];
    assign w_v4_rd.name = w_v4_rdata[NAME_W-1:0];
    assign w_v6_rd      = w_v6_rdata;

    arlo_ram #(
        .W (V4_WORD_W),
        .D (V4_DEPTH)
    ) u_v4_ram (
        .i_clk   (i_clk),
        .i_we    (w_v4_we),
        .i_addr  (AW4'(w_addr)),
        .i_wdata (w_v4_wdata),
        .o_rdata (w_v4_rdata)
    );

    arlo_ram #(
        .W (V6_WORD_W),
        .D (V6_DEPTH)
    ) u_v6_ram (
        .i_clk   (i_clk),
        .i_we    (w_v6_we),
        .i_addr  (AW6'(w_addr)),
        .i_wdata (w_v6_wdata),
        .o_rdata (w_v6_rdata)
    );

    arlo_ctrl #(
        .V4_DEPTH (V4_DEPTH),
        .V6_DEPTH (V6_DEPTH),
        .CW       (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_out        (o_out),
        .i_v4_entries (r_v4_entries),
        .i_v6_entries (r_v6_entries),
        .i_name_count (r_name_count),
        .i_v4_rd      (w_v4_rd),
        .i_v6_rd      (w_v6_rd),
        .o_v4_we      (w_v4_we),
        .o_v6_we      (w_v6_we),
        .o_addr       (w_addr)
    );

    assign w_wr_beat  = i_in.valid && i_in.ready && (i_in.command == CMD_WRITE);
    assign w_lkp_beat = i_in.valid && i_in.ready && (i_in.command == CMD_LOOKUP);

    `ARLO_ASSERT_IMP(a_we_excl, w_v4_we, !w_v6_we, "both table writes active")
    `ARLO_ASSERT_IMP(a_v4_we_src, w_v4_we, w_wr_beat && i_in.family == FAM_V4, "stray v4 write")
    `ARLO_ASSERT_IMP(a_v6_we_src, w_v6_we, w_wr_beat && i_in.family == FAM_V6, "stray v6 write")
    `ARLO_ASSERT_NXT(a_busy_after_lookup, w_lkp_beat, !i_in.ready, "ready during lookup")
endmodule
